### hdl/md4_pkg.sv
package md4_pkg;

  localparam int LenBitsDefault = 61;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [31:0] PadByte = 32'h00000080;
  localparam logic [31:0] Round2K = 32'h5a827999;
  localparam logic [31:0] Round3K = 32'h6ed9eba1;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [31:0] word_data;
    logic [2:0]  bytes_valid;
    logic        last_word;
  } md4_in_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
  } md4_out_t;

  // queue entry: one word for the block buffer, plus end-of-message mark
  typedef struct packed {
    logic [31:0] data;
    logic        msg_end;
  } md4_qword_t;

  function automatic logic [3:0] word_order(input logic [5:0] i);
    logic [3:0] s;
    s = i[3:0];
    case (i[5:4])
      2'd0: word_order = s;
      2'd1: word_order = {s[1:0], s[3:2]};
      default: word_order = {s[0], s[1], s[2], s[3]};
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    r = 5'd3;
    case ({i[5:4], i[1:0]})
      4'b0000: r = 5'd3;
      4'b0001: r = 5'd7;
      4'b0010: r = 5'd11;
      4'b0011: r = 5'd19;
      4'b0100: r = 5'd3;
      4'b0101: r = 5'd5;
      4'b0110: r = 5'd9;
      4'b0111: r = 5'd13;
      4'b1000: r = 5'd3;
      4'b1001: r = 5'd9;
      4'b1010: r = 5'd11;
      4'b1011: r = 5'd15;
      default: r = 5'd3;
    endcase
    rot_amount = r;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### hdl/md4_ram.sv
module md4_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/md4_front.sv
module md4_front
  import md4_pkg::*;
#(
  parameter int LenBits = LenBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  md4_in_t    in_item,
  output logic       busy,
  output logic       q_push,
  output md4_qword_t q_word,
  input  logic       q_full
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_LENL = 4'b0100,
    S_LENH = 4'b1000
  } fstate_t;

  fstate_t          state, state_next;
  logic [LenBits-1:0] byte_total, byte_total_next;
  logic [3:0]       widx, widx_next;
  logic             pend80, pend80_next;
  logic [63:0]      bits;
  logic [2:0]       nb;
  logic [31:0]      keep;

  assign bits = 64'(byte_total) << 3;
  assign nb = (in_item.bytes_valid > 3'd4) ? 3'd4 : in_item.bytes_valid;
  assign busy = (state != S_IDLE) || q_full;

  always_comb begin
    case (nb)
      3'd0: keep = 32'h0;
      3'd1: keep = 32'h000000ff;
      3'd2: keep = 32'h0000ffff;
      3'd3: keep = 32'h00ffffff;
      default: keep = 32'hffffffff;
    endcase
  end

  always_comb begin
    state_next = state;
    byte_total_next = byte_total;
    widx_next = widx;
    pend80_next = pend80;
    q_push = 1'b0;
    q_word = '{data: 32'h0, msg_end: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (start && !q_full) begin
          q_push = 1'b1;
          widx_next = widx + 4'd1;
          if (!in_item.last_word) begin
            byte_total_next = byte_total + LenBits'(4);
            q_word.data = in_item.word_data;
          end else begin
            byte_total_next = byte_total + LenBits'(nb);
            if (nb == 3'd4) begin
              q_word.data = in_item.word_data;
              pend80_next = 1'b1;
            end else begin
              q_word.data = (in_item.word_data & keep) | (PadByte << (5'(nb) * 5'd8));
            end
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (!q_full) begin
          if (pend80) begin
            q_push = 1'b1;
            q_word.data = PadByte;
            pend80_next = 1'b0;
            widx_next = widx + 4'd1;
          end else if (widx != 4'd14) begin
            q_push = 1'b1;
            widx_next = widx + 4'd1;
          end else begin
            state_next = S_LENL;
          end
        end
      end
      S_LENL: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_word.data = bits[31:0];
          widx_next = widx + 4'd1;
          state_next = S_LENH;
        end
      end
      S_LENH: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_word.data = bits[63:32];
          q_word.msg_end = 1'b1;
          widx_next = '0;
          byte_total_next = '0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_total <= '0;
      widx <= '0;
      pend80 <= 1'b0;
    end else begin
      state <= state_next;
      byte_total <= byte_total_next;
      widx <= widx_next;
      pend80 <= pend80_next;
    end
  end

endmodule

### hdl/md4_queue.sv
module md4_queue
  import md4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  md4_qword_t wdata,
  output logic       full,
  input  logic       pop,
  output md4_qword_t rdata,
  output logic       not_empty
);

  localparam int AW = $clog2(QueueDepth);

  md4_qword_t     slots [QueueDepth];
  logic [AW-1:0]  wptr, rptr;
  logic [AW:0]    count;

  assign full = (count == (AW+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + AW'(1);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### hdl/md4_core.sv
module md4_core
  import md4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  md4_qword_t q_word,
  output logic       q_pop,
  output logic       done,
  output md4_out_t   result,
  output logic       active
);

  typedef enum logic [3:0] {
    C_FILL = 4'b0001,
    C_PRE  = 4'b0010,
    C_STEP = 4'b0100,
    C_ADD  = 4'b1000
  } cstate_t;

  cstate_t     state;
  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [3:0]  widx;
  logic [5:0]  step;
  logic        end_mark;
  logic [3:0]  raddr;
  logic [31:0] mword;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;
  logic [5:0]  rstep;
  logic        we;

  assign q_pop = (state == C_FILL) && q_valid;
  assign we = q_pop;
  assign active = (state != C_FILL);

  // read address is for the next step (step + 1), as the buffer RAM read is registered
  assign rstep = (state == C_STEP) ? step + 6'd1 : 6'd0;
  assign raddr = word_order(rstep);

  md4_ram #(.Width(32), .Depth(16)) u_buf (
    .clk  (clk),
    .we   (we),
    .waddr(widx),
    .wdata(q_word.data),
    .raddr(raddr),
    .rdata(mword)
  );

  always_comb begin
    case (step[5:4])
      2'd0: f = (wb & wc) | (~wb & wd);
      2'd1: f = ((wb & wc) | (wb & wd) | (wc & wd)) + Round2K;
      default: f = (wb ^ wc ^ wd) + Round3K;
    endcase
    sum = wa + f + mword;
    sh = rot_amount(step);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_FILL;
      widx <= '0;
      step <= '0;
      end_mark <= 1'b0;
      done <= 1'b0;
      chain[0] <= InitA;
      chain[1] <= InitB;
      chain[2] <= InitC;
      chain[3] <= InitD;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_FILL: begin
          if (q_pop) begin
            widx <= widx + 4'd1;
            if (widx == 4'd15) begin
              end_mark <= q_word.msg_end;
              state <= C_PRE;
            end
          end
        end
        C_PRE: begin
          wa <= chain[0];
          wb <= chain[1];
          wc <= chain[2];
          wd <= chain[3];
          step <= '0;
          state <= C_STEP;
        end
        C_STEP: begin
          // rotate the register roles: new value becomes b
          wa <= wd;
          wb <= rot;
          wc <= wb;
          wd <= wc;
          step <= step + 6'd1;
          if (step == 6'd47) state <= C_ADD;
        end
        C_ADD: begin
          step <= '0;
          state <= C_FILL;
          if (end_mark) begin
            done <= 1'b1;
            result.digest_word0 <= swap32(chain[0] + wa);
            result.digest_word1 <= swap32(chain[1] + wb);
            result.digest_word2 <= swap32(chain[2] + wc);
            result.digest_word3 <= swap32(chain[3] + wd);
            chain[0] <= InitA;
            chain[1] <= InitB;
            chain[2] <= InitC;
            chain[3] <= InitD;
          end else begin
            chain[0] <= chain[0] + wa;
            chain[1] <= chain[1] + wb;
            chain[2] <= chain[2] + wc;
            chain[3] <= chain[3] + wd;
          end
        end
        default: state <= C_FILL;
      endcase
    end
  end

endmodule

### hdl/md4_hash_engine.sv
// MD4 digest engine. Words enter through a front end into a 4-word queue; the
// back end fills a 16-word buffer RAM and runs 48 round steps, one per cycle.
// Throughput: one word per cycle while busy is low (queue has room, no padding);
// the core pops no queue words while it compresses a block, so the queue fills.
// The digest strobe is registered and follows compression of the final block.
// Synchronous reset restores the MD4 initial values; results cannot be stalled.
module md4_hash_engine
  import md4_pkg::*;
#(
  parameter int LenBits = LenBitsDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  md4_in_t  in_item,
  output logic     busy,
  output logic     done,
  output md4_out_t result
);

  logic       q_push, q_full, q_pop, q_ne, core_active;
  md4_qword_t q_wr, q_rd;

  md4_front #(.LenBits(LenBits)) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .in_item(in_item),
    .busy   (busy),
    .q_push (q_push),
    .q_word (q_wr),
    .q_full (q_full)
  );

  md4_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rd),
    .not_empty(q_ne)
  );

  md4_core u_core (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_ne),
    .q_word (q_rd),
    .q_pop  (q_pop),
    .done   (done),
    .result (result),
    .active (core_active)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(q_pop && !q_ne))
    else $error("pop from empty queue");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) !(q_pop && core_active))
    else $error("queue popped during compression");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("digest strobe longer than one cycle");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import md4_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  md4_in_t  in_item;
  logic     busy;
  logic     done;
  md4_out_t result;

  md4_hash_engine u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .in_item(in_item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  localparam int WatchdogLimit = 20000;

  // predictor state
  logic [31:0] chain_q [4];
  logic [31:0] blk_q [16];
  logic [3:0]  widx_q;
  logic [60:0] total_q;

  md4_out_t digest_fifo [$];
  int errors;
  int words_sent;
  int digests_seen;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] bswap(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic int msg_index(int i);
    int s;
    s = i % 16;
    if (i < 16) return s;
    if (i < 32) return (s % 4) * 4 + s / 4;
    return ((s & 1) << 3) | ((s & 2) << 1) | ((s & 4) >> 1) | ((s & 8) >> 3);
  endfunction

  task automatic md4_compress();
    logic [31:0] w [4];
    logic [31:0] b, c, d, f;
    int t, rnd;
    int shifts [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
    for (int k = 0; k < 4; k++) w[k] = chain_q[k];
    for (int i = 0; i < 48; i++) begin
      t = (4 - (i % 4)) % 4;
      b = w[(t + 1) % 4];
      c = w[(t + 2) % 4];
      d = w[(t + 3) % 4];
      rnd = i / 16;
      if (rnd == 0) f = (b & c) | (~b & d);
      else if (rnd == 1) f = ((b & c) | (b & d) | (c & d)) + Round2K;
      else f = (b ^ c ^ d) + Round3K;
      w[t] = rol32(w[t] + f + blk_q[msg_index(i)], shifts[rnd * 4 + i % 4]);
    end
    for (int k = 0; k < 4; k++) chain_q[k] = chain_q[k] + w[k];
  endtask

  task automatic load_word(logic [31:0] v);
    blk_q[widx_q] = v;
    widx_q = widx_q + 4'd1;
    if (widx_q == 4'd0) md4_compress();
  endtask

  task automatic clear_state();
    chain_q[0] = InitA;
    chain_q[1] = InitB;
    chain_q[2] = InitC;
    chain_q[3] = InitD;
    widx_q = '0;
    total_q = '0;
  endtask

  task automatic predict_transfer(md4_in_t it);
    logic [2:0]  n;
    logic [31:0] keep;
    logic [63:0] bitlen;
    md4_out_t    exp_d;
    if (!it.last_word) begin
      total_q = total_q + 61'd4;
      load_word(it.word_data);
      return;
    end
    n = (it.bytes_valid > 3'd4) ? 3'd4 : it.bytes_valid;
    total_q = total_q + 61'(n);
    if (n == 3'd4) begin
      load_word(it.word_data);
      load_word(PadByte);
    end else begin
      keep = (n == 0) ? 32'd0 : ((32'd1 << (8 * n)) - 32'd1);
      load_word((it.word_data & keep) | (PadByte << (8 * n)));
    end
    while (widx_q != 4'd14) load_word(32'd0);
    bitlen = {3'b000, total_q} << 3;
    load_word(bitlen[31:0]);
    load_word(bitlen[63:32]);
    exp_d.digest_word0 = bswap(chain_q[0]);
    exp_d.digest_word1 = bswap(chain_q[1]);
    exp_d.digest_word2 = bswap(chain_q[2]);
    exp_d.digest_word3 = bswap(chain_q[3]);
    digest_fifo.push_back(exp_d);
    clear_state();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_word(logic [31:0] data, logic [2:0] nbytes, logic last);
    md4_in_t it;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    it.word_data = data;
    it.bytes_valid = nbytes;
    it.last_word = last;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_transfer(it);
    words_sent++;
  endtask

  // burst of words with no gap, to keep start high between transfers
  task automatic send_burst(int count, logic last_at_end, logic [2:0] nb_end);
    md4_in_t it;
    for (int i = 0; i < count; i++) begin
      it.word_data = $urandom();
      it.last_word = last_at_end && (i == count - 1);
      it.bytes_valid = it.last_word ? nb_end : 3'($urandom_range(0, 7));
      start <= 1'b1;
      in_item <= it;
      @(posedge clk);
      while (busy) @(posedge clk);
      predict_transfer(it);
      words_sent++;
    end
  endtask

  always @(posedge clk) begin
    md4_out_t exp_d;
    if (!rst && done) begin
      digests_seen++;
      if (digest_fifo.size() == 0) begin
        report_mismatch("unexpected digest", result.digest_word0, 32'h0);
      end else begin
        exp_d = digest_fifo.pop_front();
        if (result.digest_word0 !== exp_d.digest_word0)
          report_mismatch("digest_word0", result.digest_word0, exp_d.digest_word0);
        if (result.digest_word1 !== exp_d.digest_word1)
          report_mismatch("digest_word1", result.digest_word1, exp_d.digest_word1);
        if (result.digest_word2 !== exp_d.digest_word2)
          report_mismatch("digest_word2", result.digest_word2, exp_d.digest_word2);
        if (result.digest_word3 !== exp_d.digest_word3)
          report_mismatch("digest_word3", result.digest_word3, exp_d.digest_word3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired at %0t", $realtime);
      $display("md4_hash_engine regression: fail");
      $finish;
    end
  end

  task automatic test_known_vectors();
    // empty message, "a", "abc"
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h0000_0061, 3'd1, 1'b1);
    send_word(32'h0063_6261, 3'd3, 1'b1);
  endtask

  task automatic test_byte_counts();
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd5, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
    send_word(32'h0, 3'd4, 1'b0);
    send_word(32'h0, 3'd6, 1'b1);
  endtask

  task automatic test_block_edges();
    // 13 / 14 / 16 words hit the extra-block boundary
    send_burst(13, 1'b1, 3'd4);
    send_burst(14, 1'b1, 3'd0);
    send_burst(16, 1'b1, 3'd3);
  endtask

  task automatic test_random_messages();
    int len;
    while (words_sent < 800) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 1)) send_burst(1, i == len - 1, 3'($urandom_range(0, 7)));
        else send_word($urandom(), 3'($urandom_range(0, 7)), i == len - 1);
      end
    end
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    while (digest_fifo.size() != 0 && guard < WatchdogLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    digests_seen = 0;
    start = 1'b0;
    in_item = '0;
    rst = 1'b1;
    clear_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_vectors();
    test_byte_counts();
    test_block_edges();
    test_random_messages();
    start <= 1'b0;
    wait_drain();
    $display("sent %0d words, checked %0d digests", words_sent, digests_seen);
    $display("covered short tails, all byte counts and multi-block messages");
    if (errors == 0 && digest_fifo.size() == 0) begin
      $display("md4_hash_engine regression: pass");
    end else begin
      $display("%0d errors, %0d digests outstanding", errors, digest_fifo.size());
      $display("md4_hash_engine regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/md4_pkg.sv
hdl/md4_ram.sv
hdl/md4_front.sv
hdl/md4_queue.sv
hdl/md4_core.sv
hdl/md4_hash_engine.sv
sim/tb_top.sv
